// ===== rtl/fuf_pkg.sv =====
// Shared types and constants for the font unicode glyph map.
package fuf_pkg;

  // Default table depth and command queue depth
  localparam int unsigned MapDepthDefault = 1024;
  localparam int unsigned QueueDepthDefault = 4;

  // Request codes on req_type
  localparam logic [1:0] REQ_BYTE   = 2'd0;
  localparam logic [1:0] REQ_LOOKUP = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;

  // Special table bytes
  localparam logic [7:0] SEP_BYTE = 8'hFF;
  localparam logic [7:0] SEQ_BYTE = 8'hFE;

  // UTF-8 lead byte masks and patterns
  localparam logic [7:0] ASCII_MASK = 8'h80;
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_PAT  = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_PAT  = 8'hE0;

  // Entries reported in identity mode
  localparam logic [10:0] IDENTITY_USED = 11'd256;

  // Work handed from front to back
  typedef enum logic [1:0] {
    OP_WRITE,
    OP_LOOKUP,
    OP_STATUS
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [15:0] code;   // code to store or look up
    logic [15:0] glyph;  // glyph position for a store
    logic        ovf;    // overflow flag after this transaction
  } cmd_t;

  // Back end sequencer
  typedef enum logic [0:0] {
    BK_IDLE,
    BK_SEARCH
  } bk_state_t;

endpackage

// ===== rtl/fuf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module fuf_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/fuf_cmd_fifo.sv =====
// Small command queue between the front and back ends.
module fuf_cmd_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] rdata
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("command queue count beyond depth");
`endif

endmodule

// ===== rtl/fuf_front.sv =====
// Front end: takes requests, decodes table bytes, queues work for the back end.
module fuf_front #(
  parameter int unsigned MAP_DEPTH = fuf_pkg::MapDepthDefault
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            mode,
  input  logic                            push,
  output logic                            full,
  input  logic [1:0]                      req_type,
  input  logic [7:0]                      table_byte,
  input  logic                            final_byte,
  input  logic [15:0]                     code_point,
  output logic                            cmd_push,
  input  logic                            cmd_full,
  output fuf_pkg::cmd_t                   cmd,
  output logic [$clog2(MAP_DEPTH+1)-1:0]  cmd_count
);

  import fuf_pkg::*;

  localparam int unsigned CW = $clog2(MAP_DEPTH + 1);

  // Parser and table status
  logic          ovf, ovf_next;
  logic          done, done_next;
  logic          skip, skip_next;
  logic [1:0]    pend, pend_next;
  logic [15:0]   partial, partial_next;
  logic [15:0]   gpos, gpos_next;
  logic [CW-1:0] count, count_next;

  logic          accept;
  logic          fresh;
  logic          ins;
  logic [15:0]   ins_code;
  logic          store;

  assign full   = cmd_full;
  assign accept = push && !cmd_full;

  // Decode one request
  always_comb begin
    ovf_next     = ovf;
    done_next    = done;
    skip_next    = skip;
    pend_next    = pend;
    partial_next = partial;
    gpos_next    = gpos;
    count_next   = count;
    fresh        = 1'b0;
    ins          = 1'b0;
    ins_code     = '0;
    store        = 1'b0;
    unique case (req_type)
      REQ_BYTE: begin
        if (mode && !ovf && !done) begin
          // continuation handling
          if (skip) begin
            if (table_byte == SEP_BYTE) begin
              skip_next = 1'b0;
              gpos_next = gpos + 16'd1;
            end
          end else if (pend == 2'd2) begin
            if (final_byte) begin
              pend_next    = 2'd0;
              partial_next = '0;
              fresh        = 1'b1;
            end else begin
              partial_next = partial | {4'b0, table_byte[5:0], 6'b0};
              pend_next    = 2'd1;
            end
          end else if (pend == 2'd1) begin
            ins          = 1'b1;
            ins_code     = partial | {10'b0, table_byte[5:0]};
            pend_next    = 2'd0;
            partial_next = '0;
          end else begin
            fresh = 1'b1;
          end
          // lead byte handling
          if (fresh) begin
            if (table_byte == SEP_BYTE) begin
              gpos_next = gpos + 16'd1;
            end else if (table_byte == SEQ_BYTE) begin
              skip_next = 1'b1;
            end else if ((table_byte & ASCII_MASK) == 8'h00) begin
              ins      = 1'b1;
              ins_code = {8'b0, table_byte};
            end else if ((table_byte & LEAD2_MASK) == LEAD2_PAT) begin
              if (!final_byte) begin
                pend_next    = 2'd1;
                partial_next = {5'b0, table_byte[4:0], 6'b0};
              end
            end else if ((table_byte & LEAD3_MASK) == LEAD3_PAT) begin
              if (!final_byte) begin
                pend_next    = 2'd2;
                partial_next = {table_byte[3:0], 12'b0};
              end
            end
          end
          // table insert
          if (ins) begin
            if (count >= CW'(MAP_DEPTH)) begin
              ovf_next = 1'b1;
            end else begin
              store      = 1'b1;
              count_next = count + CW'(1);
            end
          end
          if (final_byte) begin
            done_next    = 1'b1;
            pend_next    = 2'd0;
            partial_next = '0;
            skip_next    = 1'b0;
          end
        end
      end
      REQ_CLEAR: begin
        ovf_next     = 1'b0;
        done_next    = 1'b0;
        skip_next    = 1'b0;
        pend_next    = 2'd0;
        partial_next = '0;
        gpos_next    = '0;
        count_next   = '0;
      end
      default: begin
      end
    endcase
  end

  // Command to the back end
  always_comb begin
    cmd_push  = accept;
    cmd.code  = (req_type == REQ_LOOKUP) ? code_point : ins_code;
    cmd.glyph = gpos;
    cmd.ovf   = ovf_next;
    cmd_count = count_next;
    if (req_type == REQ_LOOKUP) begin
      cmd.op = OP_LOOKUP;
    end else if (store) begin
      cmd.op = OP_WRITE;
    end else begin
      cmd.op = OP_STATUS;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ovf     <= 1'b0;
      done    <= 1'b0;
      skip    <= 1'b0;
      pend    <= 2'd0;
      partial <= '0;
      gpos    <= '0;
      count   <= '0;
    end else if (accept) begin
      ovf     <= ovf_next;
      done    <= done_next;
      skip    <= skip_next;
      pend    <= pend_next;
      partial <= partial_next;
      gpos    <= gpos_next;
      count   <= count_next;
    end
  end

`ifndef ASSERT_OFF
  a_ovf_only_full: assert property (@(posedge clk) disable iff (rst)
    ovf |-> (count == CW'(MAP_DEPTH)))
    else $error("overflow flagged while table has room");
  a_pend_range: assert property (@(posedge clk) disable iff (rst)
    (skip || done) |-> (pend == 2'd0))
    else $error("sequence open while skipping or after final byte");
`endif

endmodule

// ===== rtl/fuf_back.sv =====
// Back end: stores entries, scans the table for lookups, holds the result.
module fuf_back #(
  parameter int unsigned MAP_DEPTH = fuf_pkg::MapDepthDefault
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            mode,
  input  logic                            cmd_valid,
  output logic                            cmd_pop,
  input  fuf_pkg::cmd_t                   cmd,
  input  logic [$clog2(MAP_DEPTH+1)-1:0]  cmd_count,
  output logic                            empty,
  input  logic                            pop,
  output logic                            found,
  output logic [15:0]                     glyph_number,
  output logic                            table_overflow,
  output logic [10:0]                     entries_used
);

  import fuf_pkg::*;

  localparam int unsigned CW = $clog2(MAP_DEPTH + 1);
  localparam int unsigned AW = $clog2(MAP_DEPTH);

  bk_state_t     state, state_next;
  logic [CW-1:0] idx;
  logic [CW-1:0] limit;
  logic [15:0]   key;
  logic          res_valid;

  logic          slot_free;
  logic          take;
  logic          match;
  logic          ram_we;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [CW-1:0] wr_slot;
  logic [31:0]   ram_rdata;
  logic [31:0]   cnt_ext;
  logic          res_load;
  logic          res_found;
  logic [15:0]   res_glyph;
  logic          snap_load;
  logic          search_start;
  logic          search_step;

  assign slot_free = !res_valid || pop;
  assign take      = (state == BK_IDLE) && cmd_valid && slot_free;
  assign match     = (ram_rdata[15:0] == key);
  assign wr_slot   = cmd_count - CW'(1);
  assign cnt_ext   = 32'(cmd_count);
  assign empty     = !res_valid;

  fuf_ram #(
    .WIDTH(32),
    .DEPTH(MAP_DEPTH)
  ) u_map (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wr_slot[AW-1:0]),
    .wdata({cmd.glyph, cmd.code}),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (take && cmd.op == OP_LOOKUP && mode && cmd_count != '0) begin
          state_next = BK_SEARCH;
        end
      end
      BK_SEARCH: begin
        if (match || idx == limit) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // Datapath controls
  always_comb begin
    cmd_pop      = 1'b0;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_raddr    = idx[AW-1:0];
    res_load     = 1'b0;
    res_found    = 1'b0;
    res_glyph    = '0;
    snap_load    = 1'b0;
    search_start = 1'b0;
    search_step  = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (take) begin
          cmd_pop   = 1'b1;
          snap_load = 1'b1;
          unique case (cmd.op)
            OP_WRITE: begin
              ram_we   = 1'b1;
              res_load = 1'b1;
            end
            OP_LOOKUP: begin
              if (!mode) begin
                res_load  = 1'b1;
                res_found = (cmd.code[15:8] == 8'h00);
                res_glyph = res_found ? cmd.code : 16'h0000;
              end else if (cmd_count == '0) begin
                res_load = 1'b1;
              end else begin
                ram_re       = 1'b1;
                ram_raddr    = '0;
                search_start = 1'b1;
              end
            end
            default: res_load = 1'b1;
          endcase
        end
      end
      BK_SEARCH: begin
        if (match) begin
          res_load  = 1'b1;
          res_found = 1'b1;
          res_glyph = ram_rdata[31:16];
        end else if (idx == limit) begin
          res_load = 1'b1;
        end else begin
          ram_re      = 1'b1;
          search_step = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Sequencer and scan registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (search_start) begin
      idx   <= CW'(1);
      limit <= cmd_count;
      key   <= cmd.code;
    end else if (search_step) begin
      idx <= idx + CW'(1);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (snap_load || pop) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_load) begin
      table_overflow <= cmd.ovf;
      entries_used   <= mode ? cnt_ext[10:0] : IDENTITY_USED;
    end
    if (res_load) begin
      found        <= res_found;
      glyph_number <= res_glyph;
    end
  end

`ifndef ASSERT_OFF
  a_search_slot_free: assert property (@(posedge clk) disable iff (rst)
    (state == BK_SEARCH) |-> !res_valid)
    else $error("result pending during table scan");
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == BK_SEARCH) |-> (idx <= limit && idx != '0))
    else $error("scan index out of range");
  a_search_from_lookup: assert property (@(posedge clk) disable iff (rst)
    $rose(state == BK_SEARCH) |-> $past(cmd_pop && cmd.op == OP_LOOKUP))
    else $error("scan started without a lookup");
`endif

endmodule

// ===== rtl/font_unicode_glyph_map.sv =====
// A table byte, clear or status request passes the command queue and the result register to the result ports.
// Throughput: table bytes are accepted one per cycle while the queue is not full; a table-mode lookup
// holds the back end while it scans the map through the single RAM read port.
// Requests queue up to four deep while the back end scans; full rises when the queue fills.
// Reset (rst, synchronous, active high) empties the map, clears the parser, queue and
// result, and selects table mode; map contents are not cleared, only the entry count.
module font_unicode_glyph_map #(
  parameter int unsigned MAP_DEPTH = fuf_pkg::MapDepthDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  req_type,
  input  logic [7:0]  table_byte,
  input  logic        final_byte,
  input  logic [15:0] code_point,
  output logic        empty,
  input  logic        pop,
  output logic        found,
  output logic [15:0] glyph_number,
  output logic        table_overflow,
  output logic [10:0] entries_used,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data
);

  import fuf_pkg::*;

  localparam int unsigned CW = $clog2(MAP_DEPTH + 1);
  localparam int unsigned QW = $bits(cmd_t) + CW;

  logic          mode;
  logic          f_push;
  logic          q_full;
  logic          q_empty;
  logic          q_pop;
  cmd_t          f_cmd;
  logic [CW-1:0] f_count;
  cmd_t          q_cmd;
  logic [CW-1:0] q_count;
  logic [QW-1:0] q_rdata;

  // Mode register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      mode <= cfg_data;
    end
  end

  fuf_front #(
    .MAP_DEPTH(MAP_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .mode      (mode),
    .push      (push),
    .full      (full),
    .req_type  (req_type),
    .table_byte(table_byte),
    .final_byte(final_byte),
    .code_point(code_point),
    .cmd_push  (f_push),
    .cmd_full  (q_full),
    .cmd       (f_cmd),
    .cmd_count (f_count)
  );

  fuf_cmd_fifo #(
    .WIDTH(QW),
    .DEPTH(QueueDepthDefault)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (f_push),
    .wdata({f_cmd, f_count}),
    .full (q_full),
    .pop  (q_pop),
    .empty(q_empty),
    .rdata(q_rdata)
  );

  assign {q_cmd, q_count} = q_rdata;

  fuf_back #(
    .MAP_DEPTH(MAP_DEPTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .mode          (mode),
    .cmd_valid     (!q_empty),
    .cmd_pop       (q_pop),
    .cmd           (q_cmd),
    .cmd_count     (q_count),
    .empty         (empty),
    .pop           (pop),
    .found         (found),
    .glyph_number  (glyph_number),
    .table_overflow(table_overflow),
    .entries_used  (entries_used)
  );

endmodule
